>>> src/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg: shared types and constants of the heading PID controller
// Widths of the datapath, register indexes and the divider handshake structs.
// ----------------------------------------------------------------------------
package phc_pkg;

	localparam int ErrW     = 17;
	localparam int DiffW    = 18;
	localparam int IntW     = 40;
	localparam int MulAW    = 18;
	localparam int MulBW    = 21;
	localparam int ProdW    = MulAW + MulBW;
	localparam int DivMagW  = 33;
	localparam int DivDenW  = 16;
	localparam int DivNumW  = DivMagW + 16;
	localparam int DivCntW  = $clog2(DivNumW);
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] CFG_KP   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_KI   = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_KD   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_TICK = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_IUP  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_ILO  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_DB   = 3'd6;

	typedef struct packed {
		logic               start;
		logic [DivMagW-1:0] mag;
		logic [DivDenW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DivNumW-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/phc_mul.sv
// ----------------------------------------------------------------------------
// phc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module phc_mul (
	input  logic                                clk,
	input  logic signed [phc_pkg::MulAW-1:0]    a,
	input  logic signed [phc_pkg::MulBW-1:0]    b,
	output logic signed [phc_pkg::ProdW-1:0]    prod
);
	import phc_pkg::*;

	logic signed [ProdW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= ProdW'(a) * ProdW'(b);
	end

	assign prod = prod_q;

endmodule

>>> src/phc_div.sv
// ----------------------------------------------------------------------------
// phc_div: restoring divider, one quotient bit per cycle
// Divides a magnitude scaled by 2^16 by an unsigned 16-bit divisor.
// ----------------------------------------------------------------------------
module phc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  phc_pkg::div_req_t req,
	output phc_pkg::div_rsp_t rsp
);
	import phc_pkg::*;

	logic [DivDenW-1:0] rem_q;
	logic [DivDenW-1:0] divisor_q;
	logic [DivNumW-1:0] dq_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic [DivDenW+1:0] trial;
	logic               take;
	logic               last;

	assign trial = {1'b0, rem_q, dq_q[DivNumW-1]} - {2'b00, divisor_q};
	assign take  = !trial[DivDenW+1];
	assign last  = (cnt_q == DivCntW'(DivNumW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q      <= {req.mag, 16'h0000};
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? trial[DivDenW-1:0] : {rem_q[DivDenW-2:0], dq_q[DivNumW-1]};
			dq_q  <= {dq_q[DivNumW-2:0], take};
		end
	end

	assign rsp.done     = busy_q && last;
	assign rsp.quotient = dq_q;

endmodule

>>> src/pid_heading_controller_unit.sv
// ----------------------------------------------------------------------------
// pid_heading_controller_unit: heading PID controller with a dead band
// A sequencer drives one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
// Each beat passes the steps MP, MT, MI, ML, MH, MD, MR, MC, DIV and SUM in turn.
// A new beat is taken only in idle, once the last one has left the sequencer; the 49-step derivative divider dominates.
// The input side accepts a new beat while an earlier result still waits.
// Reset is asynchronous: the configuration, state and output registers return to
// their defaults and both the previous error and the integral are cleared.
module pid_heading_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,   // heading_target, heading_measured
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,   // drive
	output logic [0:0]                      m_tuser,   // error_zeroed
	input  logic                            cfg_we,
	input  logic [phc_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [phc_pkg::CfgDataW-1:0]    cfg_data
);
	import phc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_MP, S_MT, S_MI, S_ML, S_MH, S_MD, S_MR, S_MC, S_DIV, S_SUM
	} state_t;

	state_t state_q;

	logic signed [15:0] kp_q, ki_q, kd_q;
	logic        [15:0] tick_q;
	logic signed [31:0] iup_q, ilo_q;
	logic        [14:0] db_q;

	logic signed [ErrW-1:0]  err_q, prev_q;
	logic                    zeroed_q;
	logic signed [IntW-1:0]  integ_q;
	logic signed [32:0]      p_q;
	logic signed [55:0]      acc_q;
	logic signed [IntW-1:0]  iraw_q;
	logic signed [31:0]      i_q;
	logic                    neg_q;
	logic        [31:0]      drive_q;
	logic                    zero_out_q;
	logic                    m_tvalid_q;

	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [ProdW-1:0] prod;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	logic                    accept;
	logic signed [ErrW-1:0]  err_w;
	logic        [ErrW-1:0]  mag_w;
	logic                    zero_w;
	logic signed [DiffW-1:0] diff_w;
	logic signed [IntW:0]    integ_sum;
	logic signed [IntW-1:0]  integ_sat;
	logic signed [55:0]      rnd_w;
	logic signed [ProdW-1:0] prod_abs;
	logic signed [49:0]      d_w;
	logic signed [50:0]      sum_w;
	logic        [31:0]      sum_sat;
	logic                    out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign err_w  = ErrW'($signed(s_tdata[15:0])) - ErrW'($signed(s_tdata[31:16]));
	assign mag_w  = err_w[ErrW-1] ? ErrW'(-err_w) : ErrW'(err_w);
	assign zero_w = (mag_w <= {2'b00, db_q});
	assign diff_w = DiffW'(err_q) - DiffW'(prev_q);

	assign integ_sum = (IntW+1)'(integ_q) + (IntW+1)'($signed(prod[32:0]));
	always_comb begin
		if (integ_sum[IntW] != integ_sum[IntW-1]) begin
			integ_sat = integ_sum[IntW] ? {1'b1, {(IntW-1){1'b0}}} : {1'b0, {(IntW-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[IntW-1:0];
		end
	end

	assign rnd_w    = acc_q + 56'sd32768;
	assign prod_abs = prod[ProdW-1] ? -prod : prod;

	assign d_w   = neg_q ? -$signed({1'b0, div_rsp.quotient}) : $signed({1'b0, div_rsp.quotient});
	assign sum_w = 51'(p_q) + 51'(i_q) + 51'(d_w);
	always_comb begin
		if (sum_w > 51'sd2147483647) begin
			sum_sat = 32'h7FFF_FFFF;
		end else if (sum_w < -51'sd2147483648) begin
			sum_sat = 32'h8000_0000;
		end else begin
			sum_sat = sum_w[31:0];
		end
	end

	always_comb begin
		case (state_q)
			S_MP: begin
				mul_a = MulAW'(kp_q);
				mul_b = MulBW'(err_q);
			end
			S_MT: begin
				mul_a = MulAW'(err_q);
				mul_b = $signed({5'b00000, tick_q});
			end
			S_ML: begin
				mul_a = MulAW'(ki_q);
				mul_b = $signed({1'b0, integ_q[19:0]});
			end
			S_MH: begin
				mul_a = MulAW'(ki_q);
				mul_b = MulBW'($signed(integ_q[39:20]));
			end
			S_MD: begin
				mul_a = MulAW'(kd_q);
				mul_b = MulBW'(diff_w);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_req.start   = (state_q == S_MR);
	assign div_req.mag     = prod_abs[DivMagW-1:0];
	assign div_req.divisor = (tick_q == 16'h0000) ? 16'h0001 : tick_q;

	phc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	phc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= '0;
			ki_q   <= '0;
			kd_q   <= '0;
			tick_q <= 16'd655;
			iup_q  <= 32'sh7FFF_FFFF;
			ilo_q  <= 32'sh8000_0000;
			db_q   <= 15'd320;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KP:   kp_q   <= cfg_data[15:0];
				CFG_KI:   ki_q   <= cfg_data[15:0];
				CFG_KD:   kd_q   <= cfg_data[15:0];
				CFG_TICK: tick_q <= cfg_data[15:0];
				CFG_IUP:  iup_q  <= cfg_data;
				CFG_ILO:  ilo_q  <= cfg_data;
				CFG_DB:   db_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
		end else begin
			if (state_q == S_MI) begin
				integ_q <= integ_sat;
			end
			if (state_q == S_MD) begin
				prev_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q    <= zero_w ? '0 : err_w;
			zeroed_q <= zero_w;
		end
		if (state_q == S_MT) begin
			p_q <= prod[32:0];
		end
		if (state_q == S_MH) begin
			acc_q <= 56'(prod);
		end
		if (state_q == S_MD) begin
			acc_q <= acc_q + $signed({prod[35:0], 20'h00000});
		end
		if (state_q == S_MR) begin
			iraw_q <= rnd_w[55:16];
			neg_q  <= prod[ProdW-1];
		end
		if (state_q == S_MC) begin
			if (iraw_q > IntW'(iup_q)) begin
				i_q <= iup_q;
			end else if (iraw_q < IntW'(ilo_q)) begin
				i_q <= ilo_q;
			end else begin
				i_q <= iraw_q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			drive_q    <= '0;
			zero_out_q <= 1'b0;
		end else begin
			if (state_q == S_SUM && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (accept) state_q <= S_MP;
				S_MP:   state_q <= S_MT;
				S_MT:   state_q <= S_MI;
				S_MI:   state_q <= S_ML;
				S_ML:   state_q <= S_MH;
				S_MH:   state_q <= S_MD;
				S_MD:   state_q <= S_MR;
				S_MR:   state_q <= S_MC;
				S_MC:   state_q <= S_DIV;
				S_DIV:  if (div_rsp.done) state_q <= S_SUM;
				S_SUM: begin
					if (out_free) begin
						drive_q    <= sum_sat;
						zero_out_q <= zeroed_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = drive_q;
	assign m_tuser[0] = zero_out_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input accepted while an item is in progress");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide step");

	a_prev_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MD |=> prev_q == $past(err_q))
		else $error("previous error not updated");

	a_sum_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM && m_tvalid && !m_tready) |=> (state_q == S_SUM && m_tvalid))
		else $error("result overwrote a pending beat");

endmodule
